FILE: sv/etbm_pkg.sv
// Shared types, constants and helpers for the extent table block mapper.
// No dependencies; every other file of the block imports this package.
package etbm_pkg;

  localparam int SECTOR_INDEX_BITS_DEF = 40;
  localparam int TARGET_W  = 40;
  localparam int VOL_W     = 52;
  localparam int PHYS_W    = 43;
  localparam int POS_MAX_W = 49;
  localparam int LG_MIN    = 9;
  localparam int LG_MAX    = 16;
  localparam int TLOW_W    = LG_MAX - LG_MIN;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_SIZE_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_BYTES     = 1'd1;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  typedef struct packed {
    logic [7:0]          table_char;
    logic                begin_lookup;
    logic [TARGET_W-1:0] target_sector;
    logic                end_of_table;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [PHYS_W-1:0] physical_sector;
  } out_item_t;

  // Outcome of one parsed character that ends a lookup.
  typedef struct packed {
    logic                 hit;
    logic [POS_MAX_W-1:0] pos;
    logic [TLOW_W-1:0]    tlow;
  } hit_rec_t;

  // Shift of the sector size above 512 bytes, with the log2 clamped to 9..16.
  function automatic logic [2:0] lg_shift(input logic [4:0] lg);
    logic [2:0] sh;
    if (lg < 5'(LG_MIN)) begin
      sh = 3'd0;
    end else if (lg > 5'(LG_MAX)) begin
      sh = 3'(LG_MAX - LG_MIN);
    end else begin
      sh = 3'(lg - 5'(LG_MIN));
    end
    return sh;
  endfunction

endpackage

FILE: sv/etbm_parse.sv
// Allocation list parser: holds the per-lookup parse state and decides hits.
// Depends on etbm_pkg.
module etbm_parse
  import etbm_pkg::*;
#(
  parameter int SECTOR_INDEX_BITS = SECTOR_INDEX_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_item_t item,
  input  logic [2:0] sh,
  output logic     emit,
  output hit_rec_t rec
);

  localparam int AW = SECTOR_INDEX_BITS;
  localparam int OW = (AW > TARGET_W) ? AW : TARGET_W;
  localparam int PW = OW + 1;
  localparam logic [AW+3:0] ACC_MAX = {4'b0000, {AW{1'b1}}};

  logic [AW-1:0]       accum, accum_next;
  logic [AW-1:0]       start, start_next;
  logic                in_range, in_range_next;
  logic [1:0]          field_idx, field_idx_next;
  logic                digit_seen, digit_seen_next;
  // Whole sectors still to pass before the target, counted in filesystem sectors
  logic [TARGET_W-1:0] rem_hi, rem_hi_next;
  logic [TLOW_W-1:0]   tlow, tlow_next;
  logic                done, done_next;

  logic [TARGET_W-1:0] rem1;
  logic [AW-1:0]       cnt;
  logic                reversed;
  logic [AW+3:0]       prod;
  logic                hit, stop;
  logic [PW-1:0]       pos;
  logic [7:0]          c;

  always_comb begin
    accum_next      = accum;
    start_next      = start;
    in_range_next   = in_range;
    field_idx_next  = field_idx;
    digit_seen_next = digit_seen;
    rem_hi_next     = rem_hi;
    tlow_next       = tlow;
    done_next       = done;
    hit      = 1'b0;
    stop     = 1'b0;
    pos      = '0;
    rem1     = '0;
    cnt      = '0;
    reversed = 1'b0;
    prod     = '0;
    c        = item.table_char;

    if (item.begin_lookup) begin
      accum_next      = '0;
      start_next      = '0;
      in_range_next   = 1'b0;
      field_idx_next  = 2'd0;
      digit_seen_next = 1'b0;
      rem_hi_next     = item.target_sector >> sh;
      tlow_next       = item.target_sector[TLOW_W-1:0] & ~({TLOW_W{1'b1}} << sh);
      done_next       = 1'b0;
    end

    if (!done_next) begin
      if (c == CH_COMMA || c == CH_DOT) begin
        if (digit_seen_next) begin
          rem1 = rem_hi_next;
          if (in_range_next) begin
            reversed = accum_next < start_next;
            cnt      = accum_next - start_next;
            if (reversed || OW'(rem_hi_next) < OW'(cnt)) begin
              hit = 1'b1;
              pos = PW'(start_next) + PW'(rem_hi_next);
            end else begin
              rem1 = rem_hi_next - TARGET_W'(cnt);
            end
          end
          if (!hit && field_idx_next == 2'd0) begin
            if (rem1 == '0) begin
              hit = 1'b1;
              pos = PW'(accum_next);
            end else begin
              rem1 = rem1 - TARGET_W'(1);
            end
          end
          if (!hit) begin
            rem_hi_next = rem1;
          end
        end
        accum_next     = '0;
        start_next     = '0;
        in_range_next  = 1'b0;
        field_idx_next = 2'd0;
        stop           = (c == CH_DOT);
      end else if (c == CH_SEMI) begin
        if (field_idx_next != 2'd3) begin
          field_idx_next = field_idx_next + 2'd1;
        end
      end else if (c == CH_DASH) begin
        start_next     = accum_next;
        in_range_next  = 1'b1;
        field_idx_next = 2'd0;
        accum_next     = '0;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        digit_seen_next = 1'b1;
        if (field_idx_next == 2'd0) begin
          prod = (AW+4)'({accum_next, 3'b000}) + (AW+4)'({accum_next, 1'b0})
               + (AW+4)'(c[3:0]);
          accum_next = (prod > ACC_MAX) ? {AW{1'b1}} : AW'(prod);
        end
      end
    end

    emit = !done_next && (hit || stop || item.end_of_table);
    if (emit) begin
      done_next = 1'b1;
    end

    rec.hit  = hit;
    rec.pos  = POS_MAX_W'(pos);
    rec.tlow = tlow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum      <= '0;
      start      <= '0;
      in_range   <= 1'b0;
      field_idx  <= 2'd0;
      digit_seen <= 1'b0;
      rem_hi     <= '0;
      tlow       <= '0;
      done       <= 1'b1;
    end else if (fire) begin
      accum      <= accum_next;
      start      <= start_next;
      in_range   <= in_range_next;
      field_idx  <= field_idx_next;
      digit_seen <= digit_seen_next;
      rem_hi     <= rem_hi_next;
      tlow       <= tlow_next;
      done       <= done_next;
    end
  end

endmodule

FILE: sv/etbm_map.sv
// Maps a hit position to a device sector counted down from the volume end.
// Depends on etbm_pkg.
module etbm_map
  import etbm_pkg::*;
(
  input  hit_rec_t         rec,
  input  logic [VOL_W-1:0] volume_bytes,
  input  logic [2:0]       sh,
  output out_item_t        result
);

  logic [VOL_W-1:0] lim, pos_w, span, phys;
  logic             in_vol;

  always_comb begin
    lim    = ((volume_bytes - VOL_W'(1)) >> LG_MIN) >> sh;
    pos_w  = VOL_W'(rec.pos);
    in_vol = rec.hit && (volume_bytes != '0) && (pos_w < lim);
    // Only meaningful when in_vol: the span then stays below the volume size
    span   = ((pos_w + VOL_W'(1)) << LG_MIN) << sh;
    phys   = volume_bytes - span;
    result.found           = in_vol;
    result.physical_sector = in_vol ? (PHYS_W'(phys >> LG_MIN) + PHYS_W'(rec.tlow))
                                    : '0;
  end

endmodule

FILE: sv/extent_table_block_mapper.sv
// Top level of the extent table block mapper: configuration registers,
// pipeline registers and handshake. Depends on etbm_pkg, etbm_parse, etbm_map.

// Feed the allocation list one character per transfer, with begin_lookup on
// the first character of a lookup (it samples target_sector) and end_of_table
// on the last stored character. A lookup yields exactly one result transfer:
// when the running sector count passes the target, on a '.', or on end_of_table;
// characters after that are dropped until the next begin. Ranges 'a-b' are
// resolved combinationally, so the block sustains one character per clock
// unless the result side stalls. An item passes through three registers
// (input, parse outcome, result): the parse stage updates its state from the
// input register, and the mapping stage maps the parse outcome to the result.
// Write sector_size_log2 and volume_bytes only while no lookup is in flight;
// the sector size log2 is clamped to 9..16.
module extent_table_block_mapper
  import etbm_pkg::*;
#(
  parameter int SECTOR_INDEX_BITS = SECTOR_INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // character stream
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VOL_W-1:0]     cfg_data
);

  logic [4:0]       sector_size_log2;
  logic [VOL_W-1:0] volume_bytes;
  logic [2:0]       sh;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      s2_valid;
  hit_rec_t  s2_rec;

  logic      s3_take, s2_free, s1_free, fire;
  logic      emit;
  hit_rec_t  rec;
  out_item_t mapped;

  assign sh        = lg_shift(sector_size_log2);
  assign cfg_ready = 1'b1;

  // Each stage moves when the one after it is empty or moving in the same cycle
  assign s3_take  = !out_valid || !out_stall;
  assign s2_free  = !s2_valid || s3_take;
  assign fire     = s1_valid && s2_free;
  assign s1_free  = !s1_valid || fire;
  assign in_stall = !s1_free;

  etbm_parse #(
    .SECTOR_INDEX_BITS(SECTOR_INDEX_BITS)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (s1_item),
    .sh   (sh),
    .emit (emit),
    .rec  (rec)
  );

  etbm_map u_map (
    .rec          (s2_rec),
    .volume_bytes (volume_bytes),
    .sh           (sh),
    .result       (mapped)
  );

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_size_log2 <= 5'(LG_MIN);
      volume_bytes     <= '0;
      s1_valid         <= 1'b0;
      s2_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SECTOR_SIZE_LOG2: sector_size_log2 <= cfg_data[4:0];
          REG_VOLUME_BYTES:     volume_bytes     <= cfg_data;
          default: ;
        endcase
      end
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      // Only characters that end a lookup go on to the mapping stage
      if (s2_free) begin
        s2_valid <= fire && emit;
      end
      if (s3_take) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Payload: hold while stalled, advance with the matching valid
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_item <= in_data;
    end
    if (s2_free) begin
      s2_rec <= rec;
    end
    if (s3_take) begin
      out_data <= mapped;
    end
  end

endmodule
